// ===== hw/rtl/trgp_pkg.sv =====
// Shared types and constants for the threshold-guided random pixel pick block.
package trgp_pkg;

    localparam int PIX_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int RIDX_W     = 31;
    localparam int RATIO_W    = 17;
    localparam int DIM_W      = 9;
    localparam int POS_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT   = 3'd4;

    localparam logic [PIX_W-1:0]   HIGH_THR_RST = 16'd51200;
    localparam logic [PIX_W-1:0]   LOW_THR_RST  = 16'd38400;
    localparam logic [RATIO_W-1:0] RATIO_RST    = 17'd26214;
    localparam logic [DIM_W-1:0]   WIDTH_RST    = 9'd256;
    localparam logic [DIM_W-1:0]   HEIGHT_RST   = 9'd256;

    typedef struct packed {
        logic pix_accept;
        logic walk_start;
        logic miss_load;
    } trgp_cmd_t;

    typedef struct packed {
        logic last_pix;
        logic len_zero;
        logic div_done;
        logic walk_done;
    } trgp_sts_t;

endpackage

// ===== hw/rtl/trgp_div.sv =====
// Restoring divider, one quotient bit per cycle, giving the remainder only.
module trgp_div #(
    parameter int DVS_W = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [trgp_pkg::RIDX_W-1:0]   dividend,
    input  logic [DVS_W-1:0]              divisor,
    output logic                          done,
    output logic [DVS_W-1:0]              remainder
);

    localparam int CNT_W = $clog2(trgp_pkg::RIDX_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [DVS_W-1:0]             rem_reg;
    logic [DVS_W-1:0]             rem_next;
    logic [trgp_pkg::RIDX_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]             dvs_reg;
    logic [DVS_W:0]               trial;
    logic [DVS_W:0]               diff;

    assign trial = {rem_reg, dvd_reg[trgp_pkg::RIDX_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = diff[DVS_W-1:0];
        end else begin
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(trgp_pkg::RIDX_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[trgp_pkg::RIDX_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/trgp_datapath.sv =====
// Datapath: config registers, raster counters, class map, divider and map walk.
module trgp_datapath #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [trgp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [trgp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [trgp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  trgp_pkg::trgp_cmd_t               cmd,
    output trgp_pkg::trgp_sts_t               sts,
    output logic [trgp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = CW + RW;
    localparam int DW    = (CW + 1 > trgp_pkg::DIM_W) ? CW + 1 : trgp_pkg::DIM_W;
    localparam int DHW   = (RW + 1 > trgp_pkg::DIM_W) ? RW + 1 : trgp_pkg::DIM_W;
    localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int LEN_W = CNT_W + 1;

    // configuration
    logic [trgp_pkg::PIX_W-1:0]   high_thr_reg;
    logic [trgp_pkg::PIX_W-1:0]   low_thr_reg;
    logic [trgp_pkg::RATIO_W-1:0] ratio_reg;
    logic [trgp_pkg::DIM_W-1:0]   width_reg;
    logic [trgp_pkg::DIM_W-1:0]   height_reg;

    // frame state
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [CNT_W-1:0] high_cnt_reg;
    logic [CNT_W-1:0] low_cnt_reg;

    logic [CNT_W-1:0]            high_tot_reg;
    logic [LEN_W-1:0]            len_reg;

    // walk
    logic             walk_issue_reg;
    logic             rd_valid_reg;
    logic [CW-1:0]    wcol_reg;
    logic [RW-1:0]    wrow_reg;
    logic [CW-1:0]    rd_col_reg;
    logic [RW-1:0]    rd_row_reg;
    logic             rd_last_reg;
    logic [1:0]       rd_data_reg;
    logic [LEN_W-1:0] k_reg;
    logic             sel_high_reg;

    logic                      found_reg;
    logic [trgp_pkg::POS_W-1:0] pos_x_reg;
    logic [trgp_pkg::POS_W-1:0] pos_y_reg;

    logic [1:0] map_mem [0:(1 << AW)-1];

    logic [CW-1:0]    col_last;
    logic [RW-1:0]    row_last;
    logic [DW-1:0]    fw_ext;
    logic [DHW-1:0]   fh_ext;
    logic [CW-1:0]    col_cur;
    logic [RW-1:0]    row_cur;
    logic             at_last_col;
    logic             at_last_row;
    logic [trgp_pkg::PIX_W-1:0]  pix;
    logic [trgp_pkg::FRAC_W-1:0] frac;
    logic [trgp_pkg::RIDX_W-1:0] ridx;
    logic             is_high;
    logic             is_low;
    logic [CNT_W-1:0] high_new;
    logic [CNT_W-1:0] low_new;
    logic             widen;
    logic [LEN_W-1:0] len_new;
    logic             div_start;
    logic             div_done;
    logic [LEN_W-1:0] div_rem;
    logic             walk_last;
    logic             cls_bit;
    logic             hit;
    logic             walk_done;

    assign pix  = s_tdata[15:0];
    assign frac = s_tdata[31:16];
    assign ridx = s_tdata[62:32];

    always_comb begin
        fw_ext = DW'(width_reg);
        fh_ext = DHW'(height_reg);
        if (fw_ext == '0) begin
            col_last = '0;
        end else if (fw_ext > DW'(MAX_COLS)) begin
            col_last = CW'(MAX_COLS - 1);
        end else begin
            col_last = CW'(fw_ext - DW'(1));
        end
        if (fh_ext == '0) begin
            row_last = '0;
        end else if (fh_ext > DHW'(MAX_ROWS)) begin
            row_last = RW'(MAX_ROWS - 1);
        end else begin
            row_last = RW'(fh_ext - DHW'(1));
        end
    end

    assign col_cur     = (col_reg > col_last) ? col_last : col_reg;
    assign row_cur     = (row_reg > row_last) ? row_last : row_reg;
    assign at_last_col = (col_cur == col_last);
    assign at_last_row = (row_cur == row_last);

    assign is_high  = pix > high_thr_reg;
    assign is_low   = pix > low_thr_reg;
    assign high_new = high_cnt_reg + CNT_W'(is_high);
    assign low_new  = low_cnt_reg + CNT_W'(is_low);
    assign widen    = ({1'b0, frac} < ratio_reg) || (high_new == '0);
    assign len_new  = LEN_W'(high_new) + (widen ? LEN_W'(low_new) : '0);

    assign div_start = cmd.pix_accept && at_last_col && at_last_row;

    trgp_div #(
        .DVS_W(LEN_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (ridx),
        .divisor   (len_new),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign walk_last = (wcol_reg == col_last) && (wrow_reg == row_last);
    assign cls_bit   = sel_high_reg ? rd_data_reg[1] : rd_data_reg[0];
    assign hit       = rd_valid_reg && cls_bit && (k_reg == '0);
    assign walk_done = hit || (rd_valid_reg && rd_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg   <= trgp_pkg::HIGH_THR_RST;
            low_thr_reg    <= trgp_pkg::LOW_THR_RST;
            ratio_reg      <= trgp_pkg::RATIO_RST;
            width_reg      <= trgp_pkg::WIDTH_RST;
            height_reg     <= trgp_pkg::HEIGHT_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            high_cnt_reg   <= '0;
            low_cnt_reg    <= '0;
            walk_issue_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_addr)
                    trgp_pkg::REG_HIGH_THR: high_thr_reg <= cfg_data[15:0];
                    trgp_pkg::REG_LOW_THR:  low_thr_reg  <= cfg_data[15:0];
                    trgp_pkg::REG_RATIO:    ratio_reg    <= cfg_data;
                    trgp_pkg::REG_WIDTH:    width_reg    <= cfg_data[8:0];
                    trgp_pkg::REG_HEIGHT:   height_reg   <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (cmd.pix_accept) begin
                if (at_last_col && at_last_row) begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    high_cnt_reg <= '0;
                    low_cnt_reg  <= '0;
                end else begin
                    high_cnt_reg <= high_new;
                    low_cnt_reg  <= low_new;
                    if (at_last_col) begin
                        col_reg <= '0;
                        row_reg <= row_cur + RW'(1);
                    end else begin
                        col_reg <= col_cur + CW'(1);
                        row_reg <= row_cur;
                    end
                end
            end
            if (cmd.walk_start) begin
                walk_issue_reg <= 1'b1;
                rd_valid_reg   <= 1'b0;
            end else if (walk_done) begin
                walk_issue_reg <= 1'b0;
                rd_valid_reg   <= 1'b0;
            end else begin
                rd_valid_reg <= walk_issue_reg;
                if (walk_issue_reg && walk_last) begin
                    walk_issue_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_accept) begin
            map_mem[{row_cur, col_cur}] <= {is_high, is_low};
        end
        if (walk_issue_reg) begin
            rd_data_reg <= map_mem[{wrow_reg, wcol_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            high_tot_reg <= high_new;
            len_reg      <= len_new;
        end
        if (cmd.walk_start) begin
            wcol_reg <= '0;
            wrow_reg <= '0;
            if (div_rem < LEN_W'(high_tot_reg)) begin
                k_reg        <= div_rem;
                sel_high_reg <= 1'b1;
            end else begin
                k_reg        <= div_rem - LEN_W'(high_tot_reg);
                sel_high_reg <= 1'b0;
            end
        end else begin
            if (walk_issue_reg) begin
                rd_col_reg  <= wcol_reg;
                rd_row_reg  <= wrow_reg;
                rd_last_reg <= walk_last;
                if (wcol_reg == col_last) begin
                    wcol_reg <= '0;
                    wrow_reg <= wrow_reg + RW'(1);
                end else begin
                    wcol_reg <= wcol_reg + CW'(1);
                end
            end
            if (rd_valid_reg && cls_bit && k_reg != '0) begin
                k_reg <= k_reg - LEN_W'(1);
            end
        end
        if (cmd.miss_load) begin
            found_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else if (walk_done) begin
            found_reg <= hit;
            pos_x_reg <= hit ? trgp_pkg::POS_W'(rd_col_reg) : '0;
            pos_y_reg <= hit ? trgp_pkg::POS_W'(rd_row_reg) : '0;
        end
    end

    always_comb begin
        sts.last_pix  = at_last_col && at_last_row;
        sts.len_zero  = (len_reg == '0);
        sts.div_done  = div_done;
        sts.walk_done = walk_done;
    end

    assign m_tdata = {pos_y_reg, pos_x_reg};
    assign m_tuser = found_reg;

endmodule

// ===== hw/rtl/trgp_ctrl.sv =====
// Controller: frame load, remainder computation and map walk sequencing.
module trgp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  trgp_pkg::trgp_sts_t   sts,
    output trgp_pkg::trgp_cmd_t   cmd
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       ready;
    logic       accept;

    assign ready  = (state_reg == ST_LOAD) && !(sts.last_pix && out_valid_reg);
    assign accept = s_tvalid && ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.pix_accept = accept;
        cmd.walk_start = 1'b0;
        cmd.miss_load  = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (accept && sts.last_pix) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.len_zero) begin
                    cmd.miss_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end else if (sts.div_done) begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = ready;
    assign m_tvalid = out_valid_reg;

endmodule

// ===== hw/rtl/threshold_guided_random_pixel_pick.sv =====
// Top level: picks a random above-threshold pixel position of each heatmap frame.
// Pixels of a frame are taken one per cycle while loading; the last one waits while an
// older result is still unaccepted, and a non-last pixel gives no result. After the
// last pixel an empty list gives a not-found result directly; else the bit-serial
// remainder unit runs, then one class map read per entry in raster order to the chosen one.
// Reset clears counters and restores register defaults; the class map is not cleared.
module threshold_guided_random_pixel_pick #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trgp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [trgp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_value[15:0], rand_fraction[31:16], rand_index[62:32], zero[63]
    input  logic [trgp_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x[7:0], pos_y[15:8]
    output logic [trgp_pkg::M_TDATA_W-1:0]    m_tdata,
    // found[0]
    output logic                              m_tuser
);

    trgp_pkg::trgp_cmd_t cmd;
    trgp_pkg::trgp_sts_t sts;

    assign cfg_ready = 1'b1;

    trgp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    trgp_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== test/threshold_guided_random_pixel_pick_tb.sv =====
// Self-checking testbench for the threshold-guided random pixel pick block.
module threshold_guided_random_pixel_pick_tb;

    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int MAP_DEPTH      = MAX_COLS * MAX_ROWS;
    localparam int NUM_REGS       = 5;
    localparam int RANDOM_PIXELS  = 1750;
    localparam int DRAIN_CYCLES   = 400;
    localparam int TIMEOUT_CYCLES = 5000000;
    localparam int IDLE_PCT       = 32;

    localparam logic [1:0] CLS_HIGH = 2'b10;
    localparam logic [1:0] CLS_LOW  = 2'b01;

    typedef struct packed {
        logic       found;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } pick_t;

    class pixel_pick_board;
        logic [1:0]   class_map [MAP_DEPTH];
        logic [15:0]  high_thr;
        logic [15:0]  low_thr;
        logic [16:0]  ratio;
        logic [8:0]   width_reg;
        logic [8:0]   height_reg;
        logic [16:0]  high_cnt;
        logic [16:0]  low_cnt;
        logic [7:0]   row_cnt;
        logic [7:0]   col_cnt;
        pick_t        expected_picks [$];
        int           errors;

        function new();
            foreach (class_map[i]) class_map[i] = '0;
            high_thr   = trgp_pkg::HIGH_THR_RST;
            low_thr    = trgp_pkg::LOW_THR_RST;
            ratio      = trgp_pkg::RATIO_RST;
            width_reg  = trgp_pkg::WIDTH_RST;
            height_reg = trgp_pkg::HEIGHT_RST;
            high_cnt   = '0;
            low_cnt    = '0;
            row_cnt    = '0;
            col_cnt    = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [trgp_pkg::CFG_ADDR_W-1:0] idx,
                              logic [trgp_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                trgp_pkg::REG_HIGH_THR: high_thr   = val[15:0];
                trgp_pkg::REG_LOW_THR:  low_thr    = val[15:0];
                trgp_pkg::REG_RATIO:    ratio      = val[16:0];
                trgp_pkg::REG_WIDTH:    width_reg  = val[8:0];
                trgp_pkg::REG_HEIGHT:   height_reg = val[8:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_dim(logic [8:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return eff_dim(width_reg, MAX_COLS) * eff_dim(height_reg, MAX_ROWS);
        endfunction

        // k-th map entry in raster order carrying the given class bit
        function bit find_nth(int unsigned w, int unsigned h, logic [1:0] cls_bit,
                              int unsigned k, output logic [7:0] px, output logic [7:0] py);
            int unsigned remaining;
            remaining = k;
            px = '0;
            py = '0;
            for (int unsigned r = 0; r < h; r++) begin
                for (int unsigned c = 0; c < w; c++) begin
                    if ((class_map[r * MAX_COLS + c] & cls_bit) != 0) begin
                        if (remaining == 0) begin
                            px = 8'(c);
                            py = 8'(r);
                            return 1'b1;
                        end
                        remaining--;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_pixel(logic [15:0] pix, logic [15:0] frac, logic [30:0] ridx);
            int unsigned w, h, col, row, len, k;
            logic [1:0]  cls;
            logic [7:0]  px, py;
            bit          widen, hit;
            pick_t       res;
            w   = eff_dim(width_reg, MAX_COLS);
            h   = eff_dim(height_reg, MAX_ROWS);
            col = (col_cnt < w) ? col_cnt : w - 1;
            row = (row_cnt < h) ? row_cnt : h - 1;
            cls = '0;
            px  = '0;
            py  = '0;
            hit = 1'b0;
            if (pix > high_thr) begin
                cls |= CLS_HIGH;
                high_cnt++;
            end
            if (pix > low_thr) begin
                cls |= CLS_LOW;
                low_cnt++;
            end
            class_map[row * MAX_COLS + col] = cls;
            if (!(col == w - 1 && row == h - 1)) begin
                if (col == w - 1) begin
                    col_cnt = '0;
                    row_cnt = 8'(row + 1);
                end else begin
                    col_cnt = 8'(col + 1);
                    row_cnt = 8'(row);
                end
                return;
            end
            widen = (frac < ratio) || (high_cnt == 0);
            len   = high_cnt + (widen ? low_cnt : 17'd0);
            if (len != 0) begin
                k = ridx % len;
                if (k < high_cnt)
                    hit = find_nth(w, h, CLS_HIGH, k, px, py);
                else
                    hit = find_nth(w, h, CLS_LOW, k - high_cnt, px, py);
            end
            res.found = hit;
            res.pos_x = hit ? px : 8'd0;
            res.pos_y = hit ? py : 8'd0;
            expected_picks = {expected_picks, res};
            high_cnt = '0;
            low_cnt  = '0;
            row_cnt  = '0;
            col_cnt  = '0;
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $time, what);
            errors++;
        endtask

        task check_pick(logic found, logic [7:0] pos_x, logic [7:0] pos_y);
            pick_t want;
            if (expected_picks.size() == 0) begin
                report($sformatf("result with none pending: found=%b x=%0d y=%0d",
                                 found, pos_x, pos_y));
                return;
            end
            want = expected_picks.pop_front();
            if (found !== want.found)
                report($sformatf("found %b, expected %b", found, want.found));
            if (pos_x !== want.pos_x)
                report($sformatf("pos_x %0d, expected %0d", pos_x, want.pos_x));
            if (pos_y !== want.pos_y)
                report($sformatf("pos_y %0d, expected %0d", pos_y, want.pos_y));
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [trgp_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [trgp_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [trgp_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [trgp_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;

    pixel_pick_board sb;
    int              idle_pct = IDLE_PCT;
    int              pixels_sent = 0;

    threshold_guided_random_pixel_pick #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pick(m_tuser, m_tdata[7:0], m_tdata[15:8]);
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task write_config(logic [15:0] hi, logic [15:0] lo, logic [16:0] rat,
                      logic [8:0] wd, logic [8:0] ht);
        logic [trgp_pkg::CFG_ADDR_W-1:0] addrs [NUM_REGS];
        logic [trgp_pkg::CFG_DATA_W-1:0] vals  [NUM_REGS];
        addrs = '{trgp_pkg::REG_HIGH_THR, trgp_pkg::REG_LOW_THR, trgp_pkg::REG_RATIO,
                  trgp_pkg::REG_WIDTH, trgp_pkg::REG_HEIGHT};
        vals  = '{17'(hi), 17'(lo), rat, 17'(wd), 17'(ht)};
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(addrs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task send_pixel(logic [15:0] pix, logic [15:0] frac, logic [30:0] ridx);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ridx, frac, pix};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(pix, frac, ridx);
        pixels_sent++;
    endtask

    task wait_results();
        s_tvalid <= 1'b0;
        while (sb.expected_picks.size() != 0) @(posedge aclk);
    endtask

    // block may still be busy with a non-last pixel: let it settle before writing
    task wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function logic [15:0] rand_pixel(int mode);
        logic [15:0] floor_thr;
        floor_thr = (sb.high_thr < sb.low_thr) ? sb.high_thr : sb.low_thr;
        case (mode)
            0: return 16'($urandom_range(sb.high_thr));
            1: return 16'($urandom_range(floor_thr));
            default: begin
                case ($urandom_range(9))
                    0: return 16'd0;
                    1: return 16'hFFFF;
                    2: return sb.high_thr;
                    3: return sb.high_thr + 16'd1;
                    4: return sb.low_thr;
                    5: return sb.low_thr + 16'd1;
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    function logic [15:0] rand_frac();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return sb.ratio[15:0];
            3: return sb.ratio[15:0] - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [30:0] rand_index();
        case ($urandom_range(5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(15));
            default: return 31'($urandom);
        endcase
    endfunction

    task send_random_frame();
        int n, mode;
        n    = sb.frame_pixels();
        mode = $urandom_range(5);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pixel(mode), rand_frac(), rand_index());
    endtask

    task random_config();
        logic [15:0] hi, lo;
        logic [16:0] rat;
        logic [8:0]  wd, ht;
        case ($urandom_range(5))
            0: begin hi = 16'd0;    lo = 16'd0;    end
            1: begin hi = 16'hFFFF; lo = 16'hFFFF; end
            2: begin
                hi = 16'($urandom_range(32767));
                lo = 16'($urandom_range(65535, 32768));
            end
            3: begin hi = 16'($urandom); lo = 16'($urandom); end
            default: begin
                lo = 16'($urandom_range(60000));
                hi = 16'($urandom_range(65535, lo));
            end
        endcase
        case ($urandom_range(4))
            0: rat = 17'd0;
            1: rat = 17'd65536;
            2: rat = 17'd65535;
            default: rat = 17'($urandom_range(65536));
        endcase
        case ($urandom_range(9))
            0: begin wd = 9'd0; ht = 9'($urandom_range(12, 1)); end
            1: begin wd = 9'($urandom_range(12, 1)); ht = 9'd0; end
            2: begin
                wd = $urandom_range(1) ? 9'd256 : 9'($urandom_range(511, 257));
                ht = 9'($urandom_range(1));
            end
            3: begin
                wd = 9'($urandom_range(1));
                ht = $urandom_range(1) ? 9'd256 : 9'($urandom_range(511, 257));
            end
            4: begin wd = 9'd1; ht = 9'd1; end
            default: begin
                wd = 9'($urandom_range(8, 1));
                ht = 9'($urandom_range(8, 1));
            end
        endcase
        write_config(hi, lo, rat, wd, ht);
    endtask

    initial begin
        int start, phase, frames;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 2x2 frames, always widen, strict threshold edges
        write_config(trgp_pkg::HIGH_THR_RST, trgp_pkg::LOW_THR_RST, 17'd65536, 9'd2, 9'd2);
        send_pixel(16'hFFFF, 16'd0, 31'd5);
        send_pixel(16'd0, 16'hFFFF, 31'h7FFF_FFFF);
        send_pixel(16'd51201, 16'd0, 31'd0);
        send_pixel(16'd38401, 16'hFFFF, 31'h7FFF_FFFF);
        send_pixel(16'd51200, 16'd0, 31'd0);
        send_pixel(16'd38400, 16'd0, 31'd0);
        send_pixel(16'd51201, 16'd0, 31'd0);
        send_pixel(16'd0, 16'd0, 31'd0);
        wait_idle();

        // zero dimensions act as one: empty list, low only, high only
        write_config(trgp_pkg::HIGH_THR_RST, trgp_pkg::LOW_THR_RST, 17'd0, 9'd0, 9'd0);
        send_pixel(16'd0, 16'd0, 31'd7);
        send_pixel(16'd40000, 16'd0, 31'd7);
        send_pixel(16'hFFFF, 16'd0, 31'd7);
        wait_idle();

        // crossed thresholds: high without low
        write_config(16'd100, 16'd60000, 17'd0, 9'd2, 9'd1);
        send_pixel(16'd200, 16'd0, 31'd3);
        send_pixel(16'd65000, 16'd0, 31'd3);
        wait_idle();

        // frame height shrunk mid-frame
        write_config(trgp_pkg::HIGH_THR_RST, trgp_pkg::LOW_THR_RST, 17'd65536, 9'd3, 9'd3);
        for (int i = 0; i < 6; i++)
            send_pixel(16'($urandom), 16'($urandom), 31'($urandom));
        wait_idle();
        write_config(trgp_pkg::HIGH_THR_RST, trgp_pkg::LOW_THR_RST, 17'd65536, 9'd3, 9'd2);
        for (int i = 0; i < 3; i++)
            send_pixel(16'($urandom), 16'($urandom), 31'($urandom));

        start = pixels_sent;
        phase = 0;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            wait_idle();
            idle_pct = (phase >= 4 && phase < 9) ? 0 : IDLE_PCT;
            random_config();
            frames = (sb.frame_pixels() > 64) ? 1 : $urandom_range(6, 1);
            for (int f = 0; f < frames; f++) begin
                send_random_frame();
                if ($urandom_range(7) == 0)
                    wait_results();
            end
            phase++;
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("threshold_guided_random_pixel_pick_tb OK");
        else
            $display("threshold_guided_random_pixel_pick_tb NOT OK");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("threshold_guided_random_pixel_pick_tb NOT OK");
        $finish;
    end

endmodule
